>>> rtl/core/brmr_pkg.sv
// ----------------------------------------------------------------------------
// brmr_pkg
// shared constants, codes and types of the broadcast ring with many readers
// ----------------------------------------------------------------------------
package brmr_pkg;

    localparam int RING_DEPTH = 64;
    localparam int MAX_SUBS   = 8;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int SUB_AW     = 3;
    localparam int SUB_CW     = 4;
    localparam int CAP_W      = 7;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 64;
    localparam int OP_W       = 3;
    localparam int STAT_W     = 3;
    localparam int MOD_STEP   = 8;
    localparam int MOD_CHUNKS = CNT_W / MOD_STEP;
    localparam int CHUNK_AW   = $clog2(MOD_CHUNKS);

    localparam logic [OP_W-1:0] OP_SUBSCRIBE = 3'd0;
    localparam logic [OP_W-1:0] OP_PUBLISH   = 3'd1;
    localparam logic [OP_W-1:0] OP_RECEIVE   = 3'd2;
    localparam logic [OP_W-1:0] OP_POLL      = 3'd3;
    localparam logic [OP_W-1:0] OP_CLOSE     = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_LAGGED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_CLOSED = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BADID  = 3'd4;
    localparam logic [STAT_W-1:0] STAT_NOFREE = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_EXEC,
        S_RING,
        S_DONE
    } state_t;

endpackage

>>> rtl/core/brmr_if.sv
// ----------------------------------------------------------------------------
// brmr interfaces
// request, response and capacity write channels with valid and ready
// ----------------------------------------------------------------------------
interface brmr_req_if;
    logic                                valid;
    logic                                ready;
    logic [brmr_pkg::OP_W-1:0]           op;
    logic signed [brmr_pkg::DATA_W-1:0]  value;
    logic [brmr_pkg::SUB_AW-1:0]         sub_id;

    modport source (output valid, output op, output value, output sub_id, input ready);
    modport sink (input valid, input op, input value, input sub_id, output ready);
endinterface

interface brmr_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [brmr_pkg::STAT_W-1:0]         status;
    logic signed [brmr_pkg::DATA_W-1:0]  read_value;
    logic [brmr_pkg::SUB_AW-1:0]         new_sub;

    modport source (output valid, output status, output read_value, output new_sub,
                    input ready);
    modport sink (input valid, input status, input read_value, input new_sub,
                  output ready);
endinterface

interface brmr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [brmr_pkg::CAP_W-1:0]          capacity;

    modport source (output valid, output capacity, input ready);
    modport sink (input valid, input capacity, output ready);
endinterface

>>> rtl/core/brmr_ram.sv
// ----------------------------------------------------------------------------
// brmr_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module brmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/broadcast_ring_multi_reader_top.sv
// ----------------------------------------------------------------------------
// broadcast_ring_multi_reader_top
// one writer, many readers, overwriting ring with a read cursor per subscriber
// ----------------------------------------------------------------------------
// Items are handled one at a time. The cursor memory is read at the edge that
// accepts an item, and the result is then produced in steps: the 64-bit cursor
// subtract, the state update, for a receive that returns a value the ring
// memory read, and the load into the output register, which an earlier result
// still waiting there holds off. The next item can be accepted in the cycle
// after the load. The next item is taken while a result waits in the output
// register. A capacity write starts a recompute of the write slot (8 bits of
// the write count per cycle) during which no item is taken; capacity writes
// are taken only while no item is being handled and no recompute runs, and a
// capacity write offered together with an item goes first.
// ----------------------------------------------------------------------------
module broadcast_ring_multi_reader_top (
    input  logic        clk,
    input  logic        rst_n,
    brmr_req_if.sink    req,
    brmr_rsp_if.source  rsp,
    brmr_cfg_if.sink    cfg
);

    brmr_pkg::state_t                      state_reg, state_next;
    logic [brmr_pkg::OP_W-1:0]             op_reg, op_next;
    logic [brmr_pkg::DATA_W-1:0]           value_reg, value_next;
    logic [brmr_pkg::SUB_AW-1:0]           id_reg, id_next;
    logic [brmr_pkg::CNT_W-1:0]            wc_reg, wc_next;
    logic [brmr_pkg::RING_AW-1:0]          wr_slot_reg, wr_slot_next;
    logic [brmr_pkg::CAP_W-1:0]            cap_reg, cap_next;
    logic [brmr_pkg::SUB_CW-1:0]           subs_used_reg, subs_used_next;
    logic                                  closed_reg, closed_next;
    logic [brmr_pkg::CNT_W-1:0]            diff_reg, diff_next;
    logic                                  caught_reg, caught_next;
    logic                                  mod_busy_reg, mod_busy_next;
    logic [brmr_pkg::CHUNK_AW-1:0]         mod_idx_reg, mod_idx_next;
    logic [brmr_pkg::RING_AW-1:0]          mod_rem_reg, mod_rem_next;
    logic [brmr_pkg::STAT_W-1:0]           res_status_reg, res_status_next;
    logic [brmr_pkg::DATA_W-1:0]           res_value_reg, res_value_next;
    logic [brmr_pkg::SUB_AW-1:0]           res_new_sub_reg, res_new_sub_next;
    logic                                  rsp_valid_reg, rsp_valid_next;
    logic [brmr_pkg::STAT_W-1:0]           rsp_status_reg, rsp_status_next;
    logic [brmr_pkg::DATA_W-1:0]           rsp_value_reg, rsp_value_next;
    logic [brmr_pkg::SUB_AW-1:0]           rsp_new_sub_reg, rsp_new_sub_next;

    logic                                  req_fire;
    logic                                  cfg_fire;
    logic                                  rsp_free;
    logic [brmr_pkg::CAP_W-1:0]            cfg_cap;

    logic                                  cur_wr_en;
    logic [brmr_pkg::SUB_AW-1:0]           cur_wr_addr;
    logic [brmr_pkg::CNT_W-1:0]            cur_wr_data;
    logic [brmr_pkg::CNT_W-1:0]            cur_rd_data;
    logic                                  ring_wr_en;
    logic                                  ring_rd_en;
    logic [brmr_pkg::RING_AW-1:0]          ring_rd_addr;
    logic [brmr_pkg::DATA_W-1:0]           ring_rd_data;

    logic [brmr_pkg::CNT_W:0]              sub_wide;
    logic                                  bad_id;
    logic                                  lagged;
    logic [brmr_pkg::STAT_W-1:0]           look_status;
    logic [brmr_pkg::CAP_W-1:0]            lag_lo;
    logic [brmr_pkg::CAP_W-1:0]            rd_slot_wide;
    logic [brmr_pkg::CAP_W-1:0]            wr_slot_inc;
    logic [brmr_pkg::MOD_STEP-1:0]         mod_chunk;
    logic [brmr_pkg::CAP_W-1:0]            mod_r;

    assign req_fire = req.valid && req.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    assign req.ready = (state_reg == brmr_pkg::S_IDLE) && !mod_busy_reg && !cfg.valid;
    assign cfg.ready = (state_reg == brmr_pkg::S_IDLE) && !mod_busy_reg;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.read_value = rsp_value_reg;
    assign rsp.new_sub    = rsp_new_sub_reg;

    // capacity clamp
    always_comb
    begin
        if (cfg.capacity == '0)
        begin
            cfg_cap = brmr_pkg::CAP_W'(1);
        end
        else if (cfg.capacity > brmr_pkg::CAP_W'(brmr_pkg::RING_DEPTH))
        begin
            cfg_cap = brmr_pkg::CAP_W'(brmr_pkg::RING_DEPTH);
        end
        else
        begin
            cfg_cap = cfg.capacity;
        end
    end

    // cursor against write count
    assign sub_wide = {1'b0, wc_reg} - {1'b0, cur_rd_data};
    assign bad_id   = {1'b0, id_reg} >= subs_used_reg;
    assign lagged   = (diff_reg[brmr_pkg::CNT_W-1:brmr_pkg::CAP_W] != '0)
                   || (diff_reg[brmr_pkg::CAP_W-1:0] > cap_reg);
    assign lag_lo   = diff_reg[brmr_pkg::CAP_W-1:0];

    always_comb
    begin
        if (bad_id)
        begin
            look_status = brmr_pkg::STAT_BADID;
        end
        else if (caught_reg)
        begin
            look_status = closed_reg ? brmr_pkg::STAT_CLOSED : brmr_pkg::STAT_EMPTY;
        end
        else if (lagged)
        begin
            look_status = brmr_pkg::STAT_LAGGED;
        end
        else
        begin
            look_status = brmr_pkg::STAT_OK;
        end
    end

    // slot of the cursor, lag behind the write slot taken modulo capacity
    always_comb
    begin
        if ({1'b0, wr_slot_reg} >= lag_lo)
        begin
            rd_slot_wide = {1'b0, wr_slot_reg} - lag_lo;
        end
        else
        begin
            rd_slot_wide = {1'b0, wr_slot_reg} + cap_reg - lag_lo;
        end
    end

    assign ring_rd_addr = rd_slot_wide[brmr_pkg::RING_AW-1:0];
    assign wr_slot_inc  = {1'b0, wr_slot_reg} + brmr_pkg::CAP_W'(1);

    // write count modulo capacity, eight bits a cycle
    assign mod_chunk = wc_reg[mod_idx_reg * brmr_pkg::MOD_STEP +: brmr_pkg::MOD_STEP];

    always_comb
    begin
        mod_r = {1'b0, mod_rem_reg};
        for (int i = 0; i < brmr_pkg::MOD_STEP; i++)
        begin
            mod_r = {mod_r[brmr_pkg::CAP_W-2:0], mod_chunk[brmr_pkg::MOD_STEP-1-i]};
            if (mod_r >= cap_reg)
            begin
                mod_r = mod_r - cap_reg;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brmr_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = brmr_pkg::S_CALC;
                end
            end
            brmr_pkg::S_CALC:
            begin
                state_next = brmr_pkg::S_EXEC;
            end
            brmr_pkg::S_EXEC:
            begin
                if (op_reg == brmr_pkg::OP_RECEIVE && look_status == brmr_pkg::STAT_OK)
                begin
                    state_next = brmr_pkg::S_RING;
                end
                else
                begin
                    state_next = brmr_pkg::S_DONE;
                end
            end
            brmr_pkg::S_RING:
            begin
                state_next = brmr_pkg::S_DONE;
            end
            brmr_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = brmr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = brmr_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        op_next          = op_reg;
        value_next       = value_reg;
        id_next          = id_reg;
        wc_next          = wc_reg;
        wr_slot_next     = wr_slot_reg;
        cap_next         = cap_reg;
        subs_used_next   = subs_used_reg;
        closed_next      = closed_reg;
        diff_next        = diff_reg;
        caught_next      = caught_reg;
        mod_busy_next    = mod_busy_reg;
        mod_idx_next     = mod_idx_reg;
        mod_rem_next     = mod_rem_reg;
        res_status_next  = res_status_reg;
        res_value_next   = res_value_reg;
        res_new_sub_next = res_new_sub_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_value_next   = rsp_value_reg;
        rsp_new_sub_next = rsp_new_sub_reg;
        cur_wr_en        = 1'b0;
        cur_wr_addr      = id_reg;
        cur_wr_data      = wc_reg;
        ring_wr_en       = 1'b0;
        ring_rd_en       = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            brmr_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next    = req.op;
                    value_next = req.value;
                    id_next    = req.sub_id;
                end
            end
            brmr_pkg::S_CALC:
            begin
                diff_next   = sub_wide[brmr_pkg::CNT_W-1:0];
                caught_next = sub_wide[brmr_pkg::CNT_W]
                           || (sub_wide[brmr_pkg::CNT_W-1:0] == '0);
            end
            brmr_pkg::S_EXEC:
            begin
                res_status_next  = brmr_pkg::STAT_OK;
                res_value_next   = '0;
                res_new_sub_next = '0;
                unique case (op_reg)
                    brmr_pkg::OP_SUBSCRIBE:
                    begin
                        if (closed_reg)
                        begin
                            res_status_next = brmr_pkg::STAT_CLOSED;
                        end
                        else if (subs_used_reg >= brmr_pkg::SUB_CW'(brmr_pkg::MAX_SUBS))
                        begin
                            res_status_next = brmr_pkg::STAT_NOFREE;
                        end
                        else
                        begin
                            res_new_sub_next = subs_used_reg[brmr_pkg::SUB_AW-1:0];
                            cur_wr_en        = 1'b1;
                            cur_wr_addr      = subs_used_reg[brmr_pkg::SUB_AW-1:0];
                            cur_wr_data      = wc_reg;
                            subs_used_next   = subs_used_reg + brmr_pkg::SUB_CW'(1);
                        end
                    end
                    brmr_pkg::OP_PUBLISH:
                    begin
                        if (closed_reg)
                        begin
                            res_status_next = brmr_pkg::STAT_CLOSED;
                        end
                        else
                        begin
                            ring_wr_en = 1'b1;
                            wc_next    = wc_reg + brmr_pkg::CNT_W'(1);
                            if (wr_slot_inc == cap_reg)
                            begin
                                wr_slot_next = '0;
                            end
                            else
                            begin
                                wr_slot_next = wr_slot_inc[brmr_pkg::RING_AW-1:0];
                            end
                        end
                    end
                    brmr_pkg::OP_RECEIVE:
                    begin
                        res_status_next = look_status;
                        if (look_status == brmr_pkg::STAT_LAGGED)
                        begin
                            cur_wr_en   = 1'b1;
                            cur_wr_data = wc_reg - brmr_pkg::CNT_W'(cap_reg);
                        end
                        else if (look_status == brmr_pkg::STAT_OK)
                        begin
                            ring_rd_en  = 1'b1;
                            cur_wr_en   = 1'b1;
                            cur_wr_data = wc_reg - diff_reg + brmr_pkg::CNT_W'(1);
                        end
                    end
                    brmr_pkg::OP_POLL:
                    begin
                        res_status_next = look_status;
                    end
                    brmr_pkg::OP_CLOSE:
                    begin
                        closed_next = 1'b1;
                    end
                    default:
                    begin
                        res_status_next = brmr_pkg::STAT_OK;
                    end
                endcase
            end
            brmr_pkg::S_RING:
            begin
                res_value_next = ring_rd_data;
            end
            brmr_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_status_next  = res_status_reg;
                    rsp_value_next   = res_value_reg;
                    rsp_new_sub_next = res_new_sub_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_fire)
        begin
            cap_next      = cfg_cap;
            mod_busy_next = 1'b1;
            mod_idx_next  = brmr_pkg::CHUNK_AW'(brmr_pkg::MOD_CHUNKS - 1);
            mod_rem_next  = '0;
        end
        else if (mod_busy_reg)
        begin
            mod_rem_next = mod_r[brmr_pkg::RING_AW-1:0];
            mod_idx_next = mod_idx_reg - brmr_pkg::CHUNK_AW'(1);
            if (mod_idx_reg == '0)
            begin
                mod_busy_next = 1'b0;
                wr_slot_next  = mod_r[brmr_pkg::RING_AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= brmr_pkg::S_IDLE;
            wc_reg        <= '0;
            wr_slot_reg   <= '0;
            cap_reg       <= brmr_pkg::CAP_W'(brmr_pkg::RING_DEPTH);
            subs_used_reg <= '0;
            closed_reg    <= 1'b0;
            mod_busy_reg  <= 1'b0;
            mod_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wc_reg        <= wc_next;
            wr_slot_reg   <= wr_slot_next;
            cap_reg       <= cap_next;
            subs_used_reg <= subs_used_next;
            closed_reg    <= closed_next;
            mod_busy_reg  <= mod_busy_next;
            mod_idx_reg   <= mod_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        value_reg       <= value_next;
        id_reg          <= id_next;
        diff_reg        <= diff_next;
        caught_reg      <= caught_next;
        mod_rem_reg     <= mod_rem_next;
        res_status_reg  <= res_status_next;
        res_value_reg   <= res_value_next;
        res_new_sub_reg <= res_new_sub_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_value_reg   <= rsp_value_next;
        rsp_new_sub_reg <= rsp_new_sub_next;
    end

    brmr_ram #(
        .WIDTH (brmr_pkg::CNT_W),
        .DEPTH (brmr_pkg::MAX_SUBS)
    ) u_cursor_ram (
        .clk     (clk),
        .wr_en   (cur_wr_en),
        .wr_addr (cur_wr_addr),
        .wr_data (cur_wr_data),
        .rd_en   (req_fire),
        .rd_addr (req.sub_id),
        .rd_data (cur_rd_data)
    );

    brmr_ram #(
        .WIDTH (brmr_pkg::DATA_W),
        .DEPTH (brmr_pkg::RING_DEPTH)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (wr_slot_reg),
        .wr_data (value_reg),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    // checks
    a_sub_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        subs_used_reg <= brmr_pkg::SUB_CW'(brmr_pkg::MAX_SUBS))
        else $error("subscriber count above maximum");

    a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg != '0 && cap_reg <= brmr_pkg::CAP_W'(brmr_pkg::RING_DEPTH))
        else $error("capacity out of range");

    a_slot_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        !mod_busy_reg |-> {1'b0, wr_slot_reg} < cap_reg)
        else $error("write slot not below capacity");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == brmr_pkg::S_DONE))
        else $error("result loaded outside done state");

endmodule

>>> tb/broadcast_ring_multi_reader_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// broadcast_ring_multi_reader_top_test
// drives operations into the broadcast ring, predicts every response from a
// shadow of the ring, cursors and capacity, and checks the responses in order
// across several capacity settings with random idling on both channels
// ----------------------------------------------------------------------------
module broadcast_ring_multi_reader_top_test;

    localparam int HALF_PERIOD   = 6;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES    = 9;

    localparam logic [brmr_pkg::OP_W-1:0]  OP_SPARE_FIRST = 3'd5;
    localparam logic [brmr_pkg::OP_W-1:0]  OP_SPARE_MID   = 3'd6;
    localparam logic [brmr_pkg::OP_W-1:0]  OP_SPARE_LAST  = 3'd7;
    localparam logic [brmr_pkg::CAP_W-1:0] MIN_CAP        = 7'd1;
    localparam logic [brmr_pkg::CAP_W-1:0] FULL_CAP       =
        brmr_pkg::CAP_W'(brmr_pkg::RING_DEPTH);

    typedef struct packed {
        logic [brmr_pkg::OP_W-1:0]          op;
        logic signed [brmr_pkg::DATA_W-1:0] value;
        logic [brmr_pkg::SUB_AW-1:0]        sub_id;
    } ring_req_t;

    typedef struct packed {
        logic [brmr_pkg::STAT_W-1:0]        status;
        logic signed [brmr_pkg::DATA_W-1:0] read_value;
        logic [brmr_pkg::SUB_AW-1:0]        new_sub;
    } ring_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    brmr_req_if req_ch ();
    brmr_rsp_if rsp_ch ();
    brmr_cfg_if cfg_ch ();

    broadcast_ring_multi_reader_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    ring_req_t pending_ops[$];
    ring_rsp_t owed_answers[$];

    // shadow of the ring state
    logic [brmr_pkg::DATA_W-1:0] ring_mem [brmr_pkg::RING_DEPTH];
    logic [brmr_pkg::CNT_W-1:0]  pub_count;
    logic [brmr_pkg::CNT_W-1:0]  cursor [brmr_pkg::MAX_SUBS];
    logic [brmr_pkg::SUB_CW-1:0] subs_used;
    logic                        is_closed;
    logic [brmr_pkg::CAP_W-1:0]  ring_cap;

    ring_req_t req_now;
    ring_req_t next_req;
    ring_rsp_t ans_now;
    ring_rsp_t ans_want;

    logic req_taken;
    int   req_gap;
    bit   req_calm;
    int   rsp_stall;
    bit   rsp_calm;
    int   idle_cycles;
    int   fail_count;
    bit   timed_out;
    bit   stim_done;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [brmr_pkg::CAP_W-1:0] clamp_capacity(
        input logic [brmr_pkg::CAP_W-1:0] v);
        if (v == '0)
            return MIN_CAP;
        if (v > FULL_CAP)
            return FULL_CAP;
        return v;
    endfunction

    function automatic logic [brmr_pkg::RING_AW-1:0] ring_slot(
        input logic [brmr_pkg::CNT_W-1:0] c);
        logic [brmr_pkg::CNT_W-1:0] m;
        m = c % {{(brmr_pkg::CNT_W-brmr_pkg::CAP_W){1'b0}}, ring_cap};
        return m[brmr_pkg::RING_AW-1:0];
    endfunction

    function automatic logic [brmr_pkg::STAT_W-1:0] cursor_state(
        input logic [brmr_pkg::CNT_W-1:0] c);
        if (c >= pub_count)
            return is_closed ? brmr_pkg::STAT_CLOSED : brmr_pkg::STAT_EMPTY;
        if (pub_count - c > {{(brmr_pkg::CNT_W-brmr_pkg::CAP_W){1'b0}}, ring_cap})
            return brmr_pkg::STAT_LAGGED;
        return brmr_pkg::STAT_OK;
    endfunction

    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [brmr_pkg::SUB_AW-1:0] rand_id();
        return brmr_pkg::SUB_AW'($urandom_range(0, brmr_pkg::MAX_SUBS - 1));
    endfunction

    task automatic ring_apply(input ring_req_t it, output ring_rsp_t ans);
        ans.status     = brmr_pkg::STAT_OK;
        ans.read_value = '0;
        ans.new_sub    = '0;
        case (it.op)
            brmr_pkg::OP_SUBSCRIBE:
            begin
                if (is_closed)
                    ans.status = brmr_pkg::STAT_CLOSED;
                else if (subs_used >= brmr_pkg::SUB_CW'(brmr_pkg::MAX_SUBS))
                    ans.status = brmr_pkg::STAT_NOFREE;
                else
                begin
                    ans.new_sub = subs_used[brmr_pkg::SUB_AW-1:0];
                    cursor[subs_used[brmr_pkg::SUB_AW-1:0]] = pub_count;
                    subs_used = subs_used + 1'b1;
                end
            end
            brmr_pkg::OP_PUBLISH:
            begin
                if (is_closed)
                    ans.status = brmr_pkg::STAT_CLOSED;
                else
                begin
                    ring_mem[ring_slot(pub_count)] = it.value;
                    pub_count = pub_count + 1'b1;
                end
            end
            brmr_pkg::OP_RECEIVE:
            begin
                if ({1'b0, it.sub_id} >= subs_used)
                    ans.status = brmr_pkg::STAT_BADID;
                else
                begin
                    ans.status = cursor_state(cursor[it.sub_id]);
                    if (ans.status == brmr_pkg::STAT_LAGGED)
                        cursor[it.sub_id] = pub_count
                            - {{(brmr_pkg::CNT_W-brmr_pkg::CAP_W){1'b0}}, ring_cap};
                    else if (ans.status == brmr_pkg::STAT_OK)
                    begin
                        ans.read_value = ring_mem[ring_slot(cursor[it.sub_id])];
                        cursor[it.sub_id] = cursor[it.sub_id] + 1'b1;
                    end
                end
            end
            brmr_pkg::OP_POLL:
            begin
                if ({1'b0, it.sub_id} >= subs_used)
                    ans.status = brmr_pkg::STAT_BADID;
                else
                    ans.status = cursor_state(cursor[it.sub_id]);
            end
            brmr_pkg::OP_CLOSE:
            begin
                is_closed = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic queue_op(input logic [brmr_pkg::OP_W-1:0] op,
                            input logic [brmr_pkg::DATA_W-1:0] v,
                            input logic [brmr_pkg::SUB_AW-1:0] id);
        ring_req_t t;
        t.op     = op;
        t.value  = v;
        t.sub_id = id;
        pending_ops.push_back(t);
    endtask

    // sample side: prediction, checking, config shadow and watchdog
    always @(posedge clk)
    begin
        req_taken <= req_ch.valid && req_ch.ready;
        if (req_ch.valid && req_ch.ready)
        begin
            req_now.op     = req_ch.op;
            req_now.value  = req_ch.value;
            req_now.sub_id = req_ch.sub_id;
            ring_apply(req_now, ans_now);
            owed_answers.push_back(ans_now);
        end
        if (cfg_ch.valid && cfg_ch.ready)
            ring_cap = clamp_capacity(cfg_ch.capacity);
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (owed_answers.size() == 0)
            begin
                $error("unexpected item: status %0d read_value %0d new_sub %0d",
                       rsp_ch.status, rsp_ch.read_value, rsp_ch.new_sub);
                fail_count++;
            end
            else
            begin
                ans_want = owed_answers.pop_front();
                if (rsp_ch.status !== ans_want.status)
                begin
                    $error("status: expected %0d, actual %0d", ans_want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.read_value !== ans_want.read_value)
                begin
                    $error("read_value: expected %0d, actual %0d",
                           ans_want.read_value, rsp_ch.read_value);
                    fail_count++;
                end
                if (rsp_ch.new_sub !== ans_want.new_sub)
                begin
                    $error("new_sub: expected %0d, actual %0d", ans_want.new_sub, rsp_ch.new_sub);
                    fail_count++;
                end
            end
        end
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
            timed_out <= 1'b1;
    end

    // request driver
    always @(negedge clk)
    begin
        if (req_ch.valid && !req_taken)
        begin
        end
        else
        begin
            if (req_taken)
            begin
                if ($urandom_range(0, 49) == 0)
                    req_calm = !req_calm;
                req_gap = idle_len(req_calm);
            end
            if (req_gap > 0)
            begin
                req_gap = req_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                next_req = pending_ops.pop_front();
                req_ch.valid  <= 1'b1;
                req_ch.op     <= next_req.op;
                req_ch.value  <= next_req.value;
                req_ch.sub_id <= next_req.sub_id;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // response ready with random stalls
    always @(negedge clk)
    begin
        if (rsp_stall > 0)
        begin
            rsp_stall = rsp_stall - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 49) == 0)
                rsp_calm = !rsp_calm;
            if (!rsp_calm && $urandom_range(0, 3) == 0)
                rsp_stall = idle_len(1'b0);
        end
    end

    initial
    begin
        int                          n_rand;
        int                          pub_w;
        int                          pick;
        logic [brmr_pkg::CAP_W-1:0]  cap_live;
        logic [brmr_pkg::CAP_W-1:0]  phase_caps [NUM_PHASES];

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.op        = '0;
        req_ch.value     = '0;
        req_ch.sub_id    = '0;
        rsp_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.capacity  = '0;
        pub_count        = '0;
        subs_used        = '0;
        is_closed        = 1'b0;
        ring_cap         = FULL_CAP;
        req_taken        = 1'b0;
        req_gap          = 0;
        rsp_stall        = 0;
        for (int i = 0; i < brmr_pkg::MAX_SUBS; i++)
            cursor[i] = '0;

        phase_caps[0] = 7'd100;
        phase_caps[1] = 7'd0;
        phase_caps[2] = 7'd2;
        phase_caps[3] = 7'd127;
        phase_caps[4] = 7'd5;
        phase_caps[5] = 7'd1;
        phase_caps[6] = 7'd33;
        phase_caps[7] = brmr_pkg::CAP_W'($urandom_range(0, 127));
        phase_caps[8] = 7'd64;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // block must be idle before the capacity changes
            while (pending_ops.size() != 0 || req_ch.valid || owed_answers.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            @(negedge clk);
            cfg_ch.valid    <= 1'b1;
            cfg_ch.capacity <= phase_caps[ph];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            @(negedge clk);
            cfg_ch.valid <= 1'b0;

            // refill the ring under the new capacity before any receive
            cap_live = clamp_capacity(phase_caps[ph]);
            repeat (cap_live)
                queue_op(brmr_pkg::OP_PUBLISH, $urandom, rand_id());

            if (ph == 0)
            begin
                queue_op(brmr_pkg::OP_RECEIVE, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_POLL, $urandom, 3'd7);
                queue_op(brmr_pkg::OP_SUBSCRIBE, $urandom, 3'd5);
                queue_op(brmr_pkg::OP_POLL, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_RECEIVE, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_PUBLISH, 32'h7fff_ffff, 3'd7);
                queue_op(brmr_pkg::OP_PUBLISH, 32'h8000_0000, 3'd0);
                queue_op(brmr_pkg::OP_PUBLISH, 32'h0000_0000, 3'd7);
                queue_op(brmr_pkg::OP_PUBLISH, 32'hffff_ffff, 3'd0);
                queue_op(brmr_pkg::OP_SUBSCRIBE, $urandom, 3'd2);
                queue_op(brmr_pkg::OP_RECEIVE, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_RECEIVE, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_POLL, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_RECEIVE, $urandom, 3'd1);
                queue_op(OP_SPARE_FIRST, 32'hffff_ffff, 3'd7);
                queue_op(OP_SPARE_MID, $urandom, rand_id());
                queue_op(OP_SPARE_LAST, 32'h0000_0000, 3'd0);
                repeat (brmr_pkg::MAX_SUBS - 1)
                    queue_op(brmr_pkg::OP_SUBSCRIBE, $urandom, rand_id());
                queue_op(brmr_pkg::OP_RECEIVE, $urandom, 3'd7);
            end
            if (ph == 1)
            begin
                // fall behind a one-entry ring, then catch up
                repeat (3)
                    queue_op(brmr_pkg::OP_PUBLISH, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_POLL, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_RECEIVE, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_RECEIVE, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_RECEIVE, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_POLL, $urandom, 3'd0);
            end

            n_rand = $urandom_range(90, 160);
            pub_w  = $urandom_range(20, 60);
            for (int k = 0; k < n_rand; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    queue_op(brmr_pkg::OP_SUBSCRIBE, $urandom, rand_id());
                else if (pick < 4 + pub_w)
                    queue_op(brmr_pkg::OP_PUBLISH, $urandom, rand_id());
                else if (pick < 87)
                    queue_op(brmr_pkg::OP_RECEIVE, $urandom, rand_id());
                else if (pick < 97)
                    queue_op(brmr_pkg::OP_POLL, $urandom, rand_id());
                else
                    queue_op(brmr_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                             $urandom, rand_id());
            end

            if (ph == NUM_PHASES - 1)
            begin
                // after close only draining reads remain
                queue_op(brmr_pkg::OP_CLOSE, $urandom, rand_id());
                queue_op(brmr_pkg::OP_CLOSE, $urandom, rand_id());
                queue_op(brmr_pkg::OP_SUBSCRIBE, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_PUBLISH, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_POLL, $urandom, 3'd3);
                repeat (brmr_pkg::RING_DEPTH + 2)
                    queue_op(brmr_pkg::OP_RECEIVE, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_POLL, $urandom, 3'd0);
                queue_op(brmr_pkg::OP_RECEIVE, $urandom, 3'd0);
                for (int k = 0; k < 16; k++)
                    queue_op(brmr_pkg::OP_RECEIVE, $urandom, rand_id());
            end
        end

        while (pending_ops.size() != 0 || req_ch.valid || owed_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done || timed_out);
        if (!timed_out && fail_count == 0 && owed_answers.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
